// ----- hw/rtl/deadline_timer_queue_defines.svh -----
// assertion macros shared by the deadline timer queue rtl
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// property holds in the same cycle as its antecedent
`define DTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the cycle after its antecedent
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dtq_pkg.sv -----
// constants, codes and shared types of the deadline timer queue
`default_nettype none

package dtq_pkg;

    localparam int SLOTS       = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int PCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int DELAY_W = 31;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;

    // request codes
    localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    // half of the clock range, the wrap-safe boundary
    localparam logic [TIME_W-1:0] HALF_RANGE = 32'h8000_0000;

    typedef logic [IDX_W-1:0] idx_t;

    // sequencer to scan unit
    typedef struct packed {
        logic clear;
        logic step;
        logic query_mode;
        idx_t idx;
    } scan_ctl_t;

    // scan unit to sequencer
    typedef struct packed {
        logic              found;
        logic              overdue;
        logic [TIME_W-1:0] best_late;
        idx_t              best_idx;
    } scan_res_t;

    // sequencer to slot store
    typedef struct packed {
        logic              arm;
        logic              cancel;
        logic              pick;
        idx_t              widx;
        logic [TIME_W-1:0] wdl;
    } store_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/deadline_timer_queue.sv -----
// Deadline timer queue: one-shot timer slots on a 32-bit millisecond clock.
// Input channel (in_valid/in_ready) takes kind, slot and delay_ms. Arm and
// cancel act in the cycle of the transfer and give no result. Tick advances
// the clock and reports due slots, most overdue first, lower slot on ties,
// at most sixteen per tick. Query answers with one result.
// Output channel (out_valid/out_ready) carries one result per transfer; last
// marks the final result of an input item.
// A query takes one scan pass over the slots. A tick takes (k + 1) scan
// passes for k expiries; the next item is taken once the final result
// sits in the output register. Throughput is set by the single subtract and
// compare unit, which visits one slot per cycle.
// in_ready is low while a tick or query is in progress. When the receiver
// stalls the output register holds its result and the sequencer waits before
// loading the next one.
// Reset clears the clock, the armed flags and the expiry counts; deadlines
// hold no reset value and are only read for armed slots.
`default_nettype none
`include "deadline_timer_queue_defines.svh"

module deadline_timer_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [dtq_pkg::KIND_W-1:0]  kind,
    input  wire logic [dtq_pkg::SLOT_W-1:0]  slot,
    input  wire logic [dtq_pkg::DELAY_W-1:0] delay_ms,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             event_res,
    output logic [dtq_pkg::SLOT_W-1:0]       which_slot,
    output logic [dtq_pkg::CNT_W-1:0]        expire_count,
    output logic                             slot_armed,
    output logic                             any_pending,
    output logic [dtq_pkg::DELAY_W-1:0]      wait_ms,
    output logic                             last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [dtq_pkg::PCNT_W-1:0] PICK_MAX = dtq_pkg::PCNT_W'(dtq_pkg::MAX_RESULTS);
    localparam dtq_pkg::idx_t SCAN_END = dtq_pkg::IDX_W'(dtq_pkg::SLOTS - 1);

    logic [1:0]                   state_reg, state_next;
    logic [dtq_pkg::TIME_W-1:0]   now_reg, now_next;
    logic                         op_query_reg, op_query_next;
    logic [dtq_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                         in_range_reg, in_range_next;
    dtq_pkg::idx_t                scan_idx_reg, scan_idx_next;
    logic [dtq_pkg::PCNT_W-1:0]   pick_cnt_reg, pick_cnt_next;
    logic                         have_pend_reg, have_pend_next;
    dtq_pkg::idx_t                pend_idx_reg, pend_idx_next;
    logic [dtq_pkg::CNT_W-1:0]    pend_cnt_reg, pend_cnt_next;
    logic                         pend_any_reg, pend_any_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         out_event_reg, out_event_next;
    logic [dtq_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [dtq_pkg::CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                         out_armed_reg, out_armed_next;
    logic                         out_any_reg, out_any_next;
    logic [dtq_pkg::DELAY_W-1:0]  out_wait_reg, out_wait_next;
    logic                         out_last_reg, out_last_next;

    dtq_pkg::scan_ctl_t           scan_ctl;
    dtq_pkg::scan_res_t           scan_res;
    dtq_pkg::store_wr_t           store_wr;
    dtq_pkg::idx_t                rd_idx;
    logic [dtq_pkg::TIME_W-1:0]   scan_dl;
    logic                         scan_armed;
    logic [dtq_pkg::CNT_W-1:0]    rd_cnt;
    logic                         rd_armed;
    logic [dtq_pkg::SLOTS-1:0]    armed_vec;

    logic                         in_xfer;
    logic                         in_slot_ok;
    logic                         out_free;
    logic                         picking;
    logic [dtq_pkg::TIME_W-1:0]   ahead;
    logic [dtq_pkg::SLOTS-1:0]    pick_mask;

    logic                         tick_xfer;
    logic                         query_busy;
    logic                         answer_idle;

    dtq_slot_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (store_wr),
        .scan_idx   (scan_idx_reg),
        .rd_idx     (rd_idx),
        .scan_dl    (scan_dl),
        .scan_armed (scan_armed),
        .rd_cnt     (rd_cnt),
        .rd_armed   (rd_armed),
        .armed_vec  (armed_vec)
    );

    dtq_scan_unit u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .now        (now_reg),
        .dl         (scan_dl),
        .slot_armed (scan_armed),
        .res        (scan_res)
    );

    // handshake and shared decode
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        in_xfer    = in_valid && in_ready;
        in_slot_ok = (32'(slot) < dtq_pkg::SLOTS);
        out_free   = !out_valid_reg || out_ready;
        picking    = !op_query_reg && scan_res.found && (pick_cnt_reg < PICK_MAX);
        rd_idx     = op_query_reg ? dtq_pkg::IDX_W'(slot_reg) : scan_res.best_idx;
        ahead      = dtq_pkg::TIME_W'(0) - scan_res.best_late;
        pick_mask  = dtq_pkg::SLOTS'(1) << scan_res.best_idx;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        op_query_next  = op_query_reg;
        slot_next      = slot_reg;
        in_range_next  = in_range_reg;
        scan_idx_next  = scan_idx_reg;
        pick_cnt_next  = pick_cnt_reg;
        have_pend_next = have_pend_reg;
        pend_idx_next  = pend_idx_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_any_next  = pend_any_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_event_next = out_event_reg;
        out_slot_next  = out_slot_reg;
        out_cnt_next   = out_cnt_reg;
        out_armed_next = out_armed_reg;
        out_any_next   = out_any_reg;
        out_wait_next  = out_wait_reg;
        out_last_next  = out_last_reg;

        scan_ctl.clear      = 1'b0;
        scan_ctl.step       = 1'b0;
        scan_ctl.query_mode = op_query_reg;
        scan_ctl.idx        = scan_idx_reg;

        store_wr.arm    = 1'b0;
        store_wr.cancel = 1'b0;
        store_wr.pick   = 1'b0;
        store_wr.widx   = dtq_pkg::IDX_W'(slot);
        store_wr.wdl    = now_reg + dtq_pkg::TIME_W'(delay_ms);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    slot_next     = slot;
                    in_range_next = in_slot_ok;
                    unique case (kind)
                        dtq_pkg::KIND_ARM:
                        begin
                            store_wr.arm = in_slot_ok;
                        end
                        dtq_pkg::KIND_CANCEL:
                        begin
                            store_wr.cancel = in_slot_ok;
                        end
                        dtq_pkg::KIND_TICK:
                        begin
                            now_next       = now_reg + 1'b1;
                            op_query_next  = 1'b0;
                            pick_cnt_next  = '0;
                            have_pend_next = 1'b0;
                            scan_idx_next  = '0;
                            scan_ctl.clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                        dtq_pkg::KIND_QUERY:
                        begin
                            op_query_next  = 1'b1;
                            have_pend_next = 1'b0;
                            scan_idx_next  = '0;
                            scan_ctl.clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                scan_ctl.step = 1'b1;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == SCAN_END)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (op_query_reg)
                    begin
                        // query answer
                        out_valid_next = 1'b1;
                        out_event_next = 1'b1;
                        out_slot_next  = slot_reg;
                        out_cnt_next   = in_range_reg ? rd_cnt : '0;
                        out_armed_next = in_range_reg && rd_armed;
                        out_any_next   = |armed_vec;
                        out_wait_next  = (scan_res.overdue || !scan_res.found) ? '0
                                         : ahead[dtq_pkg::DELAY_W-1:0];
                        out_last_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        // release the held expiry once it is known whether more follow
                        if (have_pend_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_event_next = 1'b0;
                            out_slot_next  = dtq_pkg::SLOT_W'(pend_idx_reg);
                            out_cnt_next   = pend_cnt_reg;
                            out_armed_next = 1'b0;
                            out_any_next   = pend_any_reg;
                            out_wait_next  = '0;
                            out_last_next  = !picking;
                        end
                        if (picking)
                        begin
                            store_wr.pick  = 1'b1;
                            store_wr.widx  = scan_res.best_idx;
                            have_pend_next = 1'b1;
                            pend_idx_next  = scan_res.best_idx;
                            pend_cnt_next  = rd_cnt + 1'b1;
                            pend_any_next  = |(armed_vec & ~pick_mask);
                            pick_cnt_next  = pick_cnt_reg + 1'b1;
                            scan_idx_next  = '0;
                            scan_ctl.clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else
                        begin
                            have_pend_next = 1'b0;
                            state_next     = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            op_query_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            pick_cnt_reg  <= '0;
            have_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            op_query_reg  <= op_query_next;
            scan_idx_reg  <= scan_idx_next;
            pick_cnt_reg  <= pick_cnt_next;
            have_pend_reg <= have_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        in_range_reg  <= in_range_next;
        pend_idx_reg  <= pend_idx_next;
        pend_cnt_reg  <= pend_cnt_next;
        pend_any_reg  <= pend_any_next;
        out_event_reg <= out_event_next;
        out_slot_reg  <= out_slot_next;
        out_cnt_reg   <= out_cnt_next;
        out_armed_reg <= out_armed_next;
        out_any_reg   <= out_any_next;
        out_wait_reg  <= out_wait_next;
        out_last_reg  <= out_last_next;
    end

    // output ports
    assign out_valid    = out_valid_reg;
    assign event_res    = out_event_reg;
    assign which_slot   = out_slot_reg;
    assign expire_count = out_cnt_reg;
    assign slot_armed   = out_armed_reg;
    assign any_pending  = out_any_reg;
    assign wait_ms      = out_wait_reg;
    assign last         = out_last_reg;

    // terms for the checks
    assign tick_xfer   = in_xfer && (kind == dtq_pkg::KIND_TICK);
    assign query_busy  = (state_reg != S_IDLE) && op_query_reg;
    assign answer_idle = out_valid_reg && out_event_reg && !out_any_reg;

    // checks
    `DTQ_ASSERT_NOW(a_pick_bound, 1'b1, pick_cnt_reg <= PICK_MAX, "too many picks")
    `DTQ_ASSERT_NEXT(a_tick_adv, tick_xfer, now_reg == $past(now_reg) + 1'b1, "tick missed")
    `DTQ_ASSERT_NOW(a_query_no_pend, query_busy, !have_pend_reg, "expiry held in query")
    `DTQ_ASSERT_NOW(a_idle_wait, answer_idle, out_wait_reg == '0, "wait with nothing armed")

endmodule

`default_nettype wire

// ----- hw/rtl/dtq_slot_store.sv -----
// per-slot deadline, armed flag and expiry count storage
`default_nettype none

module dtq_slot_store (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dtq_pkg::store_wr_t        wr,
    input  wire dtq_pkg::idx_t             scan_idx,
    input  wire dtq_pkg::idx_t             rd_idx,
    output logic [dtq_pkg::TIME_W-1:0]     scan_dl,
    output logic                           scan_armed,
    output logic [dtq_pkg::CNT_W-1:0]      rd_cnt,
    output logic                           rd_armed,
    output logic [dtq_pkg::SLOTS-1:0]      armed_vec
);

    logic [dtq_pkg::TIME_W-1:0] deadline_reg [dtq_pkg::SLOTS];
    logic [dtq_pkg::SLOTS-1:0]  armed_reg;
    logic [dtq_pkg::SLOTS-1:0]  armed_next;
    logic [dtq_pkg::CNT_W-1:0]  cnt_reg  [dtq_pkg::SLOTS];
    logic [dtq_pkg::CNT_W-1:0]  cnt_next [dtq_pkg::SLOTS];

    // read ports
    assign scan_dl    = deadline_reg[scan_idx];
    assign scan_armed = armed_reg[scan_idx];
    assign rd_cnt     = cnt_reg[rd_idx];
    assign rd_armed   = armed_reg[rd_idx];
    assign armed_vec  = armed_reg;

    // armed flag and count updates
    always_comb
    begin
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        if (wr.arm)
        begin
            armed_next[wr.widx] = 1'b1;
            cnt_next[wr.widx]   = '0;
        end
        else if (wr.cancel)
        begin
            armed_next[wr.widx] = 1'b0;
        end
        else if (wr.pick)
        begin
            armed_next[wr.widx] = 1'b0;
            cnt_next[wr.widx]   = cnt_reg[wr.widx] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
            for (int i = 0; i < dtq_pkg::SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
        end
    end

    // deadline written on arm only
    always_ff @(posedge clk)
    begin
        if (wr.arm)
        begin
            deadline_reg[wr.widx] <= wr.wdl;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dtq_scan_unit.sv -----
// shared subtract and compare unit, one slot per step, keeps the earliest deadline
`default_nettype none

module dtq_scan_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dtq_pkg::scan_ctl_t        ctl,
    input  wire logic [dtq_pkg::TIME_W-1:0] now,
    input  wire logic [dtq_pkg::TIME_W-1:0] dl,
    input  wire logic                      slot_armed,
    output dtq_pkg::scan_res_t             res
);

    logic                       found_reg, found_next;
    logic                       overdue_reg, overdue_next;
    logic [dtq_pkg::TIME_W-1:0] best_late_reg, best_late_next;
    dtq_pkg::idx_t              best_idx_reg, best_idx_next;
    logic [dtq_pkg::TIME_W-1:0] late;
    logic                       late_due;
    logic                       late_overdue;
    logic                       better;
    logic                       candidate;

    // how late the slot is, wrap-safe
    always_comb
    begin
        late         = now - dl;
        late_due     = !late[dtq_pkg::TIME_W-1];
        late_overdue = late_due || (late == dtq_pkg::HALF_RANGE);
        better       = !found_reg || (late > best_late_reg);
        candidate    = ctl.query_mode ? !late_overdue : late_due;
    end

    // running maximum; ascending scan keeps the lower slot on ties
    always_comb
    begin
        found_next     = found_reg;
        overdue_next   = overdue_reg;
        best_late_next = best_late_reg;
        best_idx_next  = best_idx_reg;
        if (ctl.clear)
        begin
            found_next   = 1'b0;
            overdue_next = 1'b0;
        end
        else if (ctl.step && slot_armed)
        begin
            if (ctl.query_mode && late_overdue)
            begin
                overdue_next = 1'b1;
            end
            if (candidate && better)
            begin
                found_next     = 1'b1;
                best_late_next = late;
                best_idx_next  = ctl.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            overdue_reg <= 1'b0;
        end
        else
        begin
            found_reg   <= found_next;
            overdue_reg <= overdue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_late_reg <= best_late_next;
        best_idx_reg  <= best_idx_next;
    end

    assign res.found     = found_reg;
    assign res.overdue   = overdue_reg;
    assign res.best_late = best_late_reg;
    assign res.best_idx  = best_idx_reg;

endmodule

`default_nettype wire

// ----- tb/deadline_timer_queue_tb.sv -----
// self-checking testbench for the deadline timer queue
`timescale 1ns / 1ps

module deadline_timer_queue_tb;

    localparam int RANDOM_ITEMS = 100;
    localparam int CALM_TAIL    = 25;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int RUN_LIMIT    = 200000;
    localparam int PRINT_CAP    = 50;

    // one request to the timer unit
    typedef struct packed {
        logic [dtq_pkg::KIND_W-1:0]  kind;
        logic [dtq_pkg::SLOT_W-1:0]  slot;
        logic [dtq_pkg::DELAY_W-1:0] delay;
    } timer_req_t;

    // one expiry notice or query answer
    typedef struct packed {
        logic                        is_answer;
        logic [dtq_pkg::SLOT_W-1:0]  slot_no;
        logic [dtq_pkg::CNT_W-1:0]   count;
        logic                        armed;
        logic                        pending;
        logic [dtq_pkg::DELAY_W-1:0] wait_left;
        logic                        fin;
    } timer_note_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [dtq_pkg::KIND_W-1:0]  kind = dtq_pkg::KIND_QUERY;
    logic [dtq_pkg::SLOT_W-1:0]  slot = '0;
    logic [dtq_pkg::DELAY_W-1:0] delay_ms = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        event_res;
    logic [dtq_pkg::SLOT_W-1:0]  which_slot;
    logic [dtq_pkg::CNT_W-1:0]   expire_count;
    logic                        slot_armed;
    logic                        any_pending;
    logic [dtq_pkg::DELAY_W-1:0] wait_ms;
    logic                        last;

    // stimulus and expectations
    timer_req_t  request_q [$];
    timer_note_t note_q [$];

    // own copy of the timer state
    logic [dtq_pkg::TIME_W-1:0] model_now;
    logic [dtq_pkg::TIME_W-1:0] model_deadline [dtq_pkg::SLOTS];
    logic                       model_armed [dtq_pkg::SLOTS];
    logic [dtq_pkg::CNT_W-1:0]  model_count [dtq_pkg::SLOTS];

    int    total_items = 0;
    int    items_done = 0;
    int    ticks_done = 0;
    int    queries_done = 0;
    int    notices_seen = 0;
    int    answers_seen = 0;
    int    mismatches = 0;
    int    cycle_count = 0;
    int    gap_left = 0;
    int    stall_left = 0;
    int    seen = 0;
    int    hold_left = 0;
    logic  hold_off = 1'b0;
    logic  calm = 1'b0;

    deadline_timer_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .slot         (slot),
        .delay_ms     (delay_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .which_slot   (which_slot),
        .expire_count (expire_count),
        .slot_armed   (slot_armed),
        .any_pending  (any_pending),
        .wait_ms      (wait_ms),
        .last         (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    task automatic queue_request(input logic [dtq_pkg::KIND_W-1:0] k,
                                 input logic [dtq_pkg::SLOT_W-1:0] s,
                                 input logic [dtq_pkg::DELAY_W-1:0] d);
        timer_req_t req;
        req.kind  = k;
        req.slot  = s;
        req.delay = d;
        request_q.push_back(req);
    endtask

    function automatic logic timers_pending();
        logic any;
        any = 1'b0;
        foreach (model_armed[i])
            any |= model_armed[i];
        return any;
    endfunction

    // apply one request to the state and queue the results it causes
    task automatic advance_timers(input logic [dtq_pkg::KIND_W-1:0] k,
                                  input logic [dtq_pkg::SLOT_W-1:0] s,
                                  input logic [dtq_pkg::DELAY_W-1:0] d);
        timer_note_t                note;
        logic [dtq_pkg::TIME_W-1:0] late;
        logic [dtq_pkg::TIME_W-1:0] best;
        logic [dtq_pkg::TIME_W-1:0] ahead;
        logic                       overdue;
        logic                       found;
        int                         pick;
        int                         fired;
        note  = '0;
        fired = 0;
        case (k)
            dtq_pkg::KIND_ARM:
            begin
                if (s < dtq_pkg::SLOTS)
                begin
                    model_deadline[s] = model_now + dtq_pkg::TIME_W'(d);
                    model_armed[s]    = 1'b1;
                    model_count[s]    = '0;
                end
            end
            dtq_pkg::KIND_CANCEL:
            begin
                if (s < dtq_pkg::SLOTS)
                    model_armed[s] = 1'b0;
            end
            dtq_pkg::KIND_TICK:
            begin
                model_now = model_now + 1'b1;
                // most overdue first, lower slot wins a tie
                while (fired < dtq_pkg::MAX_RESULTS)
                begin
                    pick = -1;
                    best = '0;
                    for (int i = 0; i < dtq_pkg::SLOTS; i++)
                    begin
                        if (model_armed[i])
                        begin
                            late = model_now - model_deadline[i];
                            if (late < dtq_pkg::HALF_RANGE && (pick < 0 || late > best))
                            begin
                                pick = i;
                                best = late;
                            end
                        end
                    end
                    if (pick < 0)
                        break;
                    model_armed[pick] = 1'b0;
                    model_count[pick] = model_count[pick] + 1'b1;
                    note         = '0;
                    note.slot_no = dtq_pkg::SLOT_W'(pick);
                    note.count   = model_count[pick];
                    note.pending = timers_pending();
                    note_q.push_back(note);
                    fired++;
                end
                if (fired > 0)
                begin
                    note     = note_q.pop_back();
                    note.fin = 1'b1;
                    note_q.push_back(note);
                end
            end
            dtq_pkg::KIND_QUERY:
            begin
                // time to the earliest deadline, zero once any is due
                overdue = 1'b0;
                found   = 1'b0;
                best    = '0;
                for (int i = 0; i < dtq_pkg::SLOTS; i++)
                begin
                    if (model_armed[i])
                    begin
                        ahead = model_deadline[i] - model_now;
                        if (ahead >= dtq_pkg::HALF_RANGE || ahead == '0)
                            overdue = 1'b1;
                        else if (!found || ahead < best)
                        begin
                            best  = ahead;
                            found = 1'b1;
                        end
                    end
                end
                note.is_answer = 1'b1;
                note.slot_no   = s;
                if (s < dtq_pkg::SLOTS)
                begin
                    note.count = model_count[s];
                    note.armed = model_armed[s];
                end
                note.pending   = timers_pending();
                note.wait_left = (overdue || !found) ? '0 : best[dtq_pkg::DELAY_W-1:0];
                note.fin       = 1'b1;
                note_q.push_back(note);
            end
        endcase
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            calm     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_timers(kind, slot, delay_ms);
                if (kind == dtq_pkg::KIND_TICK)
                    ticks_done++;
                if (kind == dtq_pkg::KIND_QUERY)
                    queries_done++;
                items_done++;
            end
            calm <= (request_q.size() < CALM_TAIL);
            if (in_valid && !in_ready)
            begin
                // offered item stays until its transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                timer_req_t req;
                req = request_q.pop_front();
                kind     <= req.kind;
                slot     <= req.slot;
                delay_ms <= req.delay;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off, started on chosen transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seen      <= 0;
            hold_left <= 0;
            hold_off  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                seen <= seen + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                hold_off  <= (hold_left > 1);
            end
            else if (in_valid && in_ready && (seen == 17 || seen == 70))
            begin
                hold_left <= HOLD_CYCLES;
                hold_off  <= 1'b1;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (note_q.size() == 0)
                    report_mismatch("unexpected result, slot", which_slot, 0);
                else
                begin
                    timer_note_t want;
                    want = note_q.pop_front();
                    if (event_res !== want.is_answer)
                        report_mismatch("event_res", event_res, want.is_answer);
                    if (which_slot !== want.slot_no)
                        report_mismatch("which_slot", which_slot, want.slot_no);
                    if (expire_count !== want.count)
                        report_mismatch("expire_count", expire_count, want.count);
                    if (slot_armed !== want.armed)
                        report_mismatch("slot_armed", slot_armed, want.armed);
                    if (any_pending !== want.pending)
                        report_mismatch("any_pending", any_pending, want.pending);
                    if (wait_ms !== want.wait_left)
                        report_mismatch("wait_ms", wait_ms, want.wait_left);
                    if (last !== want.fin)
                        report_mismatch("last", last, want.fin);
                    if (want.is_answer)
                        answers_seen++;
                    else
                        notices_seen++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_off)
                out_ready <= 1'b0;
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[deadline_timer_queue] ERROR");
            $finish;
        end
    end

    initial
    begin
        int                          pick;
        logic [dtq_pkg::KIND_W-1:0]  k;
        logic [dtq_pkg::DELAY_W-1:0] d;

        // state after reset
        model_now = '0;
        foreach (model_armed[i])
        begin
            model_armed[i]    = 1'b0;
            model_count[i]    = '0;
            model_deadline[i] = '0;
        end

        // every slot armed, all due at once: full tick, ties to the lower slot
        for (int i = 0; i < dtq_pkg::SLOTS; i++)
            queue_request(dtq_pkg::KIND_ARM, dtq_pkg::SLOT_W'(i), dtq_pkg::DELAY_W'(i % 2));
        queue_request(dtq_pkg::KIND_QUERY, 4'd5, '0);
        queue_request(dtq_pkg::KIND_TICK, 4'd0, '1);
        queue_request(dtq_pkg::KIND_QUERY, 4'd0, '0);
        // longest delay, cancel twice, short delay to expiry
        queue_request(dtq_pkg::KIND_ARM, 4'd15, '1);
        queue_request(dtq_pkg::KIND_QUERY, 4'd15, '0);
        queue_request(dtq_pkg::KIND_ARM, 4'd0, 31'd1);
        queue_request(dtq_pkg::KIND_CANCEL, 4'd15, '1);
        queue_request(dtq_pkg::KIND_CANCEL, 4'd15, '0);
        queue_request(dtq_pkg::KIND_QUERY, 4'd15, '1);
        queue_request(dtq_pkg::KIND_TICK, 4'd15, '0);

        // random mix, mostly short delays so that slots keep expiring
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            d    = dtq_pkg::DELAY_W'($urandom());
            if (pick < 35)
            begin
                k = dtq_pkg::KIND_ARM;
                if ($urandom_range(0, 4) != 0)
                    d = dtq_pkg::DELAY_W'($urandom_range(0, 6));
            end
            else if (pick < 45)
                k = dtq_pkg::KIND_CANCEL;
            else if (pick < 80)
                k = dtq_pkg::KIND_TICK;
            else
                k = dtq_pkg::KIND_QUERY;
            queue_request(k, dtq_pkg::SLOT_W'($urandom_range(0, 15)), d);
        end
        total_items = request_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (items_done != total_items || note_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d ticks, %0d queries), two long hold-offs",
                 items_done, ticks_done, queries_done);
        $display("checked %0d expiry notices and %0d query answers, %0d mismatches",
                 notices_seen, answers_seen, mismatches);
        if (mismatches == 0)
            $display("[deadline_timer_queue] OK");
        else
            $display("[deadline_timer_queue] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_slot_store.sv
hw/rtl/dtq_scan_unit.sv
hw/rtl/deadline_timer_queue.sv
tb/deadline_timer_queue_tb.sv
